[hw/rtl/fpa_pkg.sv]
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WORD_BITS = 32;
  localparam int DVD_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DIV_STAGES = DVD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0] uword_t;

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_GT       = 4'd4,
    ACT_LT       = 4'd5,
    ACT_GE       = 4'd6,
    ACT_LE       = 4'd7,
    ACT_EQ       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_FROM_INT = 4'd14,
    ACT_TO_INT   = 4'd15
  } action_t;

  typedef struct packed {
    logic   is_div;
    logic   neg;
    word_t  result;
    logic   cmp;
    logic   dz;
  } tag_t;

endpackage

[hw/rtl/fpa_in_if.sv]
interface fpa_in_if;
  logic               valid;
  logic               ready;
  fpa_pkg::action_t   action;
  fpa_pkg::word_t     operand_a;
  fpa_pkg::word_t     operand_b;

  modport source (output valid, output action, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input action, input operand_a, input operand_b,
                output ready);
endinterface

[hw/rtl/fpa_out_if.sv]
interface fpa_out_if;
  logic             valid;
  logic             ready;
  fpa_pkg::word_t   result_raw;
  logic             compare_true;
  logic             divide_by_zero;

  modport source (output valid, output result_raw, output compare_true,
                  output divide_by_zero, input ready);
  modport sink (input valid, input result_raw, input compare_true,
                input divide_by_zero, output ready);
endinterface

[hw/rtl/fpa_div.sv]
module fpa_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  fpa_pkg::tag_t                          in_tag,
  input  logic [fpa_pkg::DVD_BITS-1:0]           dividend,
  input  fpa_pkg::uword_t                        divisor,
  output logic                                   out_valid,
  output fpa_pkg::tag_t                          out_tag,
  output logic [fpa_pkg::DVD_BITS-1:0]           quotient
);
  import fpa_pkg::*;

  logic                  valid [DIV_STAGES];
  tag_t                  tag   [DIV_STAGES];
  uword_t                dvs   [DIV_STAGES];
  uword_t                rem   [DIV_STAGES];
  logic [DVD_BITS-1:0]   work  [DIV_STAGES];

  uword_t                rem_next  [DIV_STAGES];
  logic [DVD_BITS-1:0]   work_next [DIV_STAGES];

  // Each stage retires one quotient bit of a restoring division.
  always_comb begin
    logic [WORD_BITS:0]  trial;
    logic [WORD_BITS:0]  diff;
    uword_t              r_in;
    logic [DVD_BITS-1:0] w_in;
    uword_t              d_in;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        r_in = '0;
        w_in = dividend;
        d_in = divisor;
      end else begin
        r_in = rem[k-1];
        w_in = work[k-1];
        d_in = dvs[k-1];
      end
      trial = {r_in, w_in[DVD_BITS-1]};
      diff  = trial - {1'b0, d_in};
      if (trial >= {1'b0, d_in}) begin
        rem_next[k]  = diff[WORD_BITS-1:0];
        work_next[k] = {w_in[DVD_BITS-2:0], 1'b1};
      end else begin
        rem_next[k]  = trial[WORD_BITS-1:0];
        work_next[k] = {w_in[DVD_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) valid[k] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) valid[k] <= valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
      dvs[0] <= divisor;
      for (int k = 1; k < DIV_STAGES; k++) begin
        tag[k] <= tag[k-1];
        dvs[k] <= dvs[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem[k]  <= rem_next[k];
        work[k] <= work_next[k];
      end
    end
  end

  assign out_valid = valid[DIV_STAGES-1];
  assign out_tag   = tag[DIV_STAGES-1];
  assign quotient  = work[DIV_STAGES-1];
endmodule

[hw/rtl/fixed_point_alu.sv]
// An accepted input beat passes the input register, the stage-2 register, the
// 40-stage divider pipeline, which sets the depth, and the output register.
// Throughput: one beat per cycle, but a stalled output holds the whole pipeline.
// Reset (synchronous, active high) clears all valid bits but no data registers.
module fixed_point_alu (
  input  logic  clk,
  input  logic  rst,
  fpa_in_if.sink    in,
  fpa_out_if.source out
);
  import fpa_pkg::*;

  logic    en;

  logic    s1_valid;
  action_t s1_action;
  word_t   s1_a;
  word_t   s1_b;

  logic                        s2_valid;
  tag_t                        s2_tag;
  logic                        s2_is_mul;
  logic signed [2*WORD_BITS-1:0] s2_prod;
  logic [DVD_BITS-1:0]         s2_dvd;
  uword_t                      s2_dvs;

  tag_t                  s1_tag;
  uword_t                mag_a;
  uword_t                mag_b;
  tag_t                  div_in_tag;
  logic                  div_valid;
  tag_t                  div_tag;
  logic [DVD_BITS-1:0]   div_quot;
  uword_t                quot_lo;
  word_t                 final_result;

  logic    o_valid;
  word_t   o_result;
  logic    o_cmp;
  logic    o_dz;

  assign en       = !o_valid || out.ready;
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (en) begin
      s1_valid <= in.valid;
      s2_valid <= s1_valid;
      o_valid  <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_action <= in.action;
      s1_a      <= in.operand_a;
      s1_b      <= in.operand_b;
    end
  end

  always_comb begin
    logic lt_ab;
    logic lt_ba;
    lt_ab  = s1_a < s1_b;
    lt_ba  = s1_b < s1_a;
    mag_a  = s1_a[WORD_BITS-1] ? uword_t'(-s1_a) : uword_t'(s1_a);
    mag_b  = s1_b[WORD_BITS-1] ? uword_t'(-s1_b) : uword_t'(s1_b);
    s1_tag = '0;
    s1_tag.neg = s1_a[WORD_BITS-1] ^ s1_b[WORD_BITS-1];
    unique case (s1_action)
      ACT_ADD:      s1_tag.result = s1_a + s1_b;
      ACT_SUB:      s1_tag.result = s1_a - s1_b;
      ACT_MUL:      s1_tag.result = '0;
      ACT_DIV: begin
        s1_tag.is_div = (s1_b != '0);
        s1_tag.dz     = (s1_b == '0);
      end
      ACT_GT:       s1_tag.cmp = lt_ba;
      ACT_LT:       s1_tag.cmp = lt_ab;
      ACT_GE:       s1_tag.cmp = !lt_ab;
      ACT_LE:       s1_tag.cmp = !lt_ba;
      ACT_EQ:       s1_tag.cmp = (s1_a == s1_b);
      ACT_NE:       s1_tag.cmp = (s1_a != s1_b);
      ACT_MIN:      s1_tag.result = lt_ab ? s1_a : s1_b;
      ACT_MAX:      s1_tag.result = lt_ba ? s1_a : s1_b;
      ACT_INC:      s1_tag.result = s1_a + word_t'(1);
      ACT_DEC:      s1_tag.result = s1_a - word_t'(1);
      ACT_FROM_INT: s1_tag.result = s1_a <<< FRAC_BITS;
      ACT_TO_INT:   s1_tag.result = s1_a >>> FRAC_BITS;
      default:      s1_tag.result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag    <= s1_tag;
      s2_is_mul <= (s1_action == ACT_MUL);
      s2_prod   <= s1_a * s1_b;
      s2_dvd    <= {mag_a, {FRAC_BITS{1'b0}}};
      s2_dvs    <= mag_b;
    end
  end

  always_comb begin
    div_in_tag = s2_tag;
    if (s2_is_mul) begin
      div_in_tag.result = s2_prod[FRAC_BITS +: WORD_BITS];
    end
  end

  fpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .in_tag    (div_in_tag),
    .dividend  (s2_dvd),
    .divisor   (s2_dvs),
    .out_valid (div_valid),
    .out_tag   (div_tag),
    .quotient  (div_quot)
  );

  always_comb begin
    quot_lo = div_quot[WORD_BITS-1:0];
    if (div_tag.is_div) begin
      final_result = div_tag.neg ? word_t'(-quot_lo) : word_t'(quot_lo);
    end else begin
      final_result = div_tag.result;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_result <= final_result;
      o_cmp    <= div_tag.cmp;
      o_dz     <= div_tag.dz;
    end
  end

  assign out.valid          = o_valid;
  assign out.result_raw     = o_result;
  assign out.compare_true   = o_cmp;
  assign out.divide_by_zero = o_dz;

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.divide_by_zero |-> out.result_raw == '0)
    else $error("divide by zero beat carries a nonzero result");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.compare_true |-> out.result_raw == '0 && !out.divide_by_zero)
    else $error("comparison beat carries a result or divide flag");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(div_quot) && $stable(div_valid))
    else $error("divider pipeline moved during a stall");
endmodule

[tb/fixed_point_alu_test.sv]
module fixed_point_alu_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  typedef struct packed {
    word_t result_raw;
    logic  compare_true;
    logic  divide_by_zero;
  } alu_result_t;

  typedef struct packed {
    action_t     action;
    word_t       operand_a;
    word_t       operand_b;
    logic        has_expected;
    alu_result_t expected;
  } directed_row_t;

  localparam int LATENCY = 43;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 530;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   error_count = 0;
  int   beats_sent = 0;
  int   beats_checked = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_recv = 1'b0;

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_alu u_dut (.clk(clk), .rst(rst), .in(in_ch), .out(out_ch));

  alu_result_t pending_results[$];
  alu_result_t pinned_results[$];
  logic        pinned_valid[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alu_result_t compute_alu(action_t act, word_t a, word_t b);
    alu_result_t r;
    logic signed [63:0] product;
    logic signed [WORD_BITS+FRAC_BITS-1:0] dividend;
    logic signed [WORD_BITS+FRAC_BITS-1:0] quotient;
    r = '0;
    case (act)
      ACT_ADD: r.result_raw = a + b;
      ACT_SUB: r.result_raw = a - b;
      ACT_MUL: begin
        product = 64'(a) * 64'(b);
        product = product >>> FRAC_BITS;
        r.result_raw = product[WORD_BITS-1:0];
      end
      ACT_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          dividend = (WORD_BITS+FRAC_BITS)'(a) <<< FRAC_BITS;
          quotient = dividend / (WORD_BITS+FRAC_BITS)'(b);
          r.result_raw = quotient[WORD_BITS-1:0];
        end
      end
      ACT_GT: r.compare_true = a > b;
      ACT_LT: r.compare_true = a < b;
      ACT_GE: r.compare_true = a >= b;
      ACT_LE: r.compare_true = a <= b;
      ACT_EQ: r.compare_true = a == b;
      ACT_NE: r.compare_true = a != b;
      ACT_MIN: r.result_raw = (a < b) ? a : b;
      ACT_MAX: r.result_raw = (a > b) ? a : b;
      ACT_INC: r.result_raw = a + 1;
      ACT_DEC: r.result_raw = a - 1;
      ACT_FROM_INT: r.result_raw = a <<< FRAC_BITS;
      default: r.result_raw = a >>> FRAC_BITS;
    endcase
    return r;
  endfunction

  function automatic word_t random_operand();
    case ($urandom_range(0, 7))
      0: return word_t'($urandom_range(0, 4)) - 2;
      1: return 32'sh7FFFFFFF - word_t'($urandom_range(0, 2));
      2: return 32'sh80000000 + word_t'($urandom_range(0, 2));
      3: return word_t'($signed($urandom_range(0, 65535)) - 32768);
      4: return word_t'($urandom_range(0, 1) ? 256 : -256);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic directed_row_t make_row(action_t act, word_t a, word_t b, logic known,
                                             word_t res, logic cmp, logic dz);
    directed_row_t row;
    row.action = act;
    row.operand_a = a;
    row.operand_b = b;
    row.has_expected = known;
    row.expected.result_raw = res;
    row.expected.compare_true = cmp;
    row.expected.divide_by_zero = dz;
    return row;
  endfunction

  directed_row_t directed_rows[$];

  task automatic send_beat(action_t act, word_t a, word_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    pending_results.push_back(compute_alu(act, a, b));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_recv && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("Result beat with no expectation: result_raw %h", out_ch.result_raw);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (pinned_results.size() != 0) begin
          if (pinned_valid.pop_front()) exp_r = pinned_results.pop_front();
          else void'(pinned_results.pop_front());
        end
        beats_checked++;
        if (out_ch.result_raw !== exp_r.result_raw) begin
          $error("result_raw expected %h actual %h", exp_r.result_raw, out_ch.result_raw);
          error_count++;
        end
        if (out_ch.compare_true !== exp_r.compare_true) begin
          $error("compare_true expected %b actual %b", exp_r.compare_true,
                 out_ch.compare_true);
          error_count++;
        end
        if (out_ch.divide_by_zero !== exp_r.divide_by_zero) begin
          $error("divide_by_zero expected %b actual %b", exp_r.divide_by_zero,
                 out_ch.divide_by_zero);
          error_count++;
        end
      end
    end
  end

  initial begin
    directed_row_t row;
    int settle;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    directed_rows.push_back(make_row(ACT_ADD, 32'sh7FFFFFFF, 32'sd1, 1, 32'sh80000000, 0, 0));
    directed_rows.push_back(make_row(ACT_SUB, 32'sh80000000, 32'sd1, 1, 32'sh7FFFFFFF, 0, 0));
    directed_rows.push_back(make_row(ACT_MUL, 32'sd256, 32'sd256, 1, 32'sd256, 0, 0));
    directed_rows.push_back(make_row(ACT_MUL, -32'sd1, 32'sd1, 1, -32'sd1, 0, 0));
    directed_rows.push_back(make_row(ACT_MUL, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_MUL, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_DIV, 32'sd1234, 32'sd0, 1, 32'sd0, 0, 1));
    directed_rows.push_back(make_row(ACT_DIV, 32'sh80000000, 32'sd1, 0, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_DIV, -32'sd3, 32'sd2, 0, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_DIV, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_GT, 32'sh7FFFFFFF, 32'sh80000000, 1, 0, 1, 0));
    directed_rows.push_back(make_row(ACT_LT, 32'sh7FFFFFFF, 32'sh80000000, 1, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_GE, 32'sd5, 32'sd5, 1, 0, 1, 0));
    directed_rows.push_back(make_row(ACT_LE, 32'sd6, 32'sd5, 1, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_EQ, -32'sd1, -32'sd1, 1, 0, 1, 0));
    directed_rows.push_back(make_row(ACT_NE, -32'sd1, -32'sd1, 1, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_MIN, 32'sd7, 32'sd7, 0, 0, 0, 0));
    directed_rows.push_back(make_row(ACT_MAX, 32'sh80000000, 32'sh7FFFFFFF, 1,
                                     32'sh7FFFFFFF, 0, 0));
    directed_rows.push_back(make_row(ACT_INC, 32'sh7FFFFFFF, 32'sd9, 1, 32'sh80000000, 0, 0));
    directed_rows.push_back(make_row(ACT_DEC, 32'sh80000000, 32'sd9, 1, 32'sh7FFFFFFF, 0, 0));
    directed_rows.push_back(make_row(ACT_FROM_INT, 32'sh00800001, 32'sd0, 1,
                                     32'sh80000100, 0, 0));
    directed_rows.push_back(make_row(ACT_TO_INT, -32'sd1, 32'sd0, 1, -32'sd1, 0, 0));
    directed_rows.push_back(make_row(ACT_TO_INT, 32'sh7FFFFFFF, 32'sd0, 1, 32'sh007FFFFF, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      pinned_results.push_back(row.expected);
      pinned_valid.push_back(row.has_expected);
      send_beat(row.action, row.operand_a, row.operand_b);
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < RANDOM_BEATS / 3; n++) begin
        if (phase == 2 && n == 20) hold_recv <= 1'b1;
        if (n == 120) drain();
        send_beat(action_t'($urandom_range(0, 15)), random_operand(), random_operand());
      end
    end
    drain();

    settle = 0;
    while (settle < LATENCY + 10) begin
      @(posedge clk);
      settle++;
    end

    $display("Checked %0d result beats from %0d input beats over all actions,",
             beats_checked, beats_sent);
    $display("with operand extremes, back-pressure and idle gaps on both sides.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The receiver hold is released here.
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_recv) begin
        held++;
        if (held == 200) hold_recv <= 1'b0;
      end
    end
  end
endmodule
